// ===== sv/cluster_direction_decider_unit_assert.svh =====
// ----------------------------------------------------------------------------
// cluster direction decider assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef CLUSTER_DIRECTION_DECIDER_UNIT_ASSERT_SVH
`define CLUSTER_DIRECTION_DECIDER_UNIT_ASSERT_SVH

// same-cycle implication
`define CDD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdd_pkg
// shared types, phase codes and constants of the cluster direction decider
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned StepW   = 5;

  localparam logic [CfgIdxW-1:0] REG_START_W    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_T    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_END_W      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_END_T      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WIRE_INV   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TIME_INV   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MIN_CHARGE = 3'd6;

  localparam logic [DataW-1:0] INV_PITCH_RST  = 16'd4096;
  localparam logic [DataW-1:0] MIN_CHARGE_RST = 16'd25;

  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_SCALE = 3'd1;
  localparam logic [PhaseW-1:0] PH_NORM  = 3'd2;
  localparam logic [PhaseW-1:0] PH_PROD  = 3'd3;
  localparam logic [PhaseW-1:0] PH_SQRT  = 3'd4;
  localparam logic [PhaseW-1:0] PH_DIV   = 3'd5;
  localparam logic [PhaseW-1:0] PH_ACC   = 3'd6;
  localparam logic [PhaseW-1:0] PH_DONE  = 3'd7;

  localparam logic [StepW-1:0] SCALE_LAST = 5'd6;
  localparam logic [StepW-1:0] PROD_LAST  = 5'd7;
  localparam logic [StepW-1:0] SQRT_LAST  = 5'd30;
  localparam logic [StepW-1:0] DIV_LAST   = 5'd17;
  localparam logic [StepW-1:0] ACC_LAST   = 5'd2;
  localparam logic [StepW-1:0] STEP_MAX   = 5'd31;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [StepW-1:0]  step;
    logic              dir;
    logic              accept;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic used;
    logic last;
    logic norm_done;
    logic zero_vec;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/cdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdd_ctrl
// sequencer that walks one used hit through scale, normalize, products, square
// root, division and accumulation; after a last hit it feeds the output stage
// ----------------------------------------------------------------------------
module cdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hit_valid_i,
  output logic              hit_ready_o,
  input  cdd_pkg::status_t  status_i,
  output cdd_pkg::cmd_t     cmd_o
);
  import cdd_pkg::*;

  logic [PhaseW-1:0] state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              dir_q, dir_d;
  logic              accept;
  logic              emit;

  assign hit_ready_o = (state_q == PH_IDLE);
  assign accept      = hit_valid_i && hit_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = (step_q == STEP_MAX) ? step_q : step_q + 5'd1;
    dir_d   = dir_q;
    emit    = 1'b0;
    case (state_q)
      PH_IDLE: begin
        step_d = '0;
        if (accept) begin
          dir_d   = 1'b0;
          state_d = status_i.used ? PH_SCALE : PH_DONE;
        end
      end
      PH_SCALE: begin
        if (step_q == SCALE_LAST) begin
          state_d = PH_NORM;
          step_d  = '0;
        end
      end
      PH_NORM: begin
        if (step_q != '0 && status_i.norm_done) begin
          state_d = status_i.zero_vec ? PH_DONE : PH_PROD;
          step_d  = '0;
        end
      end
      PH_PROD: begin
        if (step_q == PROD_LAST) begin
          state_d = PH_SQRT;
          step_d  = '0;
        end
      end
      PH_SQRT: begin
        if (step_q == SQRT_LAST) begin
          state_d = PH_DIV;
          step_d  = '0;
        end
      end
      PH_DIV: begin
        if (step_q == DIV_LAST) begin
          state_d = PH_ACC;
          step_d  = '0;
        end
      end
      PH_ACC: begin
        if (step_q == ACC_LAST) begin
          step_d = '0;
          if (dir_q) begin
            state_d = PH_DONE;
          end else begin
            dir_d   = 1'b1;
            state_d = PH_PROD;
          end
        end
      end
      PH_DONE: begin
        step_d = '0;
        if (!status_i.last) begin
          state_d = PH_IDLE;
        end else if (!status_i.out_busy) begin
          emit    = 1'b1;
          state_d = PH_IDLE;
        end
      end
      default: begin
        state_d = PH_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      step_q  <= '0;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dir_q   <= dir_d;
    end
  end

  assign cmd_o.phase  = state_q;
  assign cmd_o.step   = step_q;
  assign cmd_o.dir    = dir_q;
  assign cmd_o.accept = accept;
  assign cmd_o.emit   = emit;

endmodule

// ===== sv/cdd_datapath.sv =====
// ----------------------------------------------------------------------------
// cdd_datapath
// configuration registers, shared multiplier, normalizer, bit-serial square
// root and divider, saturating sums and the result register
// ----------------------------------------------------------------------------
module cdd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cdd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cdd_pkg::DataW-1:0]   cfg_data_i,
  input  logic [cdd_pkg::DataW-1:0]   hit_w_i,
  input  logic [cdd_pkg::DataW-1:0]   hit_t_i,
  input  logic [cdd_pkg::DataW-1:0]   hit_charge_i,
  input  logic                        last_hit_i,
  input  logic                        res_ready_i,
  input  cdd_pkg::cmd_t               cmd_i,
  output cdd_pkg::status_t            status_o,
  output logic                        res_valid_o,
  output logic                        swap_ends_o,
  output logic [cdd_pkg::DataW-1:0]   used_hits_o,
  output logic                        degenerate_o
);
  import cdd_pkg::*;

  localparam logic signed [39:0] CosMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] CosMin = {1'b1, {39{1'b0}}};

  logic [15:0] start_w_q, start_t_q, end_w_q, end_t_q;
  logic [15:0] wire_inv_q, time_inv_q, min_charge_q;
  logic [15:0] hw_q, ht_q;
  logic        last_q;

  logic signed [39:0] fsum_q, bsum_q;
  logic [47:0]        fsq_q, bsq_q;
  logic [15:0]        count_q;
  logic               any_used_q, degen_seen_q;

  logic signed [32:0] raw_q [6];
  logic [31:0]        magx_q [3];
  logic [31:0]        magy_q [3];
  logic [2:0]         sgx_q, sgy_q;

  logic [31:0]        na_q, nb_q;
  logic signed [31:0] dot_q;
  logic signed [63:0] p_q;
  logic [61:0]        rad_q;
  logic [30:0]        root_q;
  logic [31:0]        srem_q;
  logic [31:0]        drem_q;
  logic [16:0]        nbits_q;
  logic [16:0]        quo_q;
  logic signed [16:0] c_q;

  logic        res_valid_q;
  logic        swap_q, degen_out_q;
  logic [15:0] used_q;

  // operand selection
  logic signed [16:0] dsel;
  logic [15:0]        isel;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [15:0] cx [3];
  logic signed [15:0] cy [3];
  logic [1:0]         hv;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      cx[v] = sgx_q[v] ? -$signed({1'b0, magx_q[v][14:0]}) : $signed({1'b0, magx_q[v][14:0]});
      cy[v] = sgy_q[v] ? -$signed({1'b0, magy_q[v][14:0]}) : $signed({1'b0, magy_q[v][14:0]});
    end
  end

  assign hv = cmd_i.dir ? 2'd2 : 2'd1;

  always_comb begin
    dsel = '0;
    isel = '0;
    case (cmd_i.step[2:0])
      3'd0: begin
        dsel = $signed({1'b0, end_w_q}) - $signed({1'b0, start_w_q}); isel = wire_inv_q;
      end
      3'd1: begin
        dsel = $signed({1'b0, end_t_q}) - $signed({1'b0, start_t_q}); isel = time_inv_q;
      end
      3'd2: begin
        dsel = $signed({1'b0, hw_q}) - $signed({1'b0, start_w_q}); isel = wire_inv_q;
      end
      3'd3: begin
        dsel = $signed({1'b0, ht_q}) - $signed({1'b0, start_t_q}); isel = time_inv_q;
      end
      3'd4: begin
        dsel = $signed({1'b0, hw_q}) - $signed({1'b0, end_w_q}); isel = wire_inv_q;
      end
      3'd5: begin
        dsel = $signed({1'b0, ht_q}) - $signed({1'b0, end_t_q}); isel = time_inv_q;
      end
      default: begin
        dsel = '0; isel = '0;
      end
    endcase
  end

  always_comb begin
    mul_a = {{16{dsel[16]}}, dsel};
    mul_b = $signed({17'b0, isel});
    if (cmd_i.phase == PH_PROD) begin
      case (cmd_i.step[2:0])
        3'd0: begin
          mul_a = 33'(cx[0]); mul_b = 33'(cx[0]);
        end
        3'd1: begin
          mul_a = 33'(cy[0]); mul_b = 33'(cy[0]);
        end
        3'd2: begin
          mul_a = 33'(cx[hv]); mul_b = 33'(cx[hv]);
        end
        3'd3: begin
          mul_a = 33'(cy[hv]); mul_b = 33'(cy[hv]);
        end
        3'd4: begin
          mul_a = 33'(cx[0]); mul_b = 33'(cx[hv]);
        end
        3'd5: begin
          mul_a = 33'(cy[0]); mul_b = 33'(cy[hv]);
        end
        3'd6: begin
          mul_a = $signed({1'b0, na_q}); mul_b = $signed({1'b0, nb_q});
        end
        default: begin
          mul_a = '0; mul_b = '0;
        end
      endcase
    end else if (cmd_i.phase == PH_ACC) begin
      mul_a = 33'(c_q);
      mul_b = 33'(c_q);
    end
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    p_q <= prod[63:0];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_w_q    <= '0;
      start_t_q    <= '0;
      end_w_q      <= '0;
      end_t_q      <= '0;
      wire_inv_q   <= INV_PITCH_RST;
      time_inv_q   <= INV_PITCH_RST;
      min_charge_q <= MIN_CHARGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_W:    start_w_q    <= cfg_data_i;
        REG_START_T:    start_t_q    <= cfg_data_i;
        REG_END_W:      end_w_q      <= cfg_data_i;
        REG_END_T:      end_t_q      <= cfg_data_i;
        REG_WIRE_INV:   wire_inv_q   <= cfg_data_i;
        REG_TIME_INV:   time_inv_q   <= cfg_data_i;
        REG_MIN_CHARGE: min_charge_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic used_now;
  assign used_now = (hit_charge_i >= min_charge_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hw_q   <= hit_w_i;
      ht_q   <= hit_t_i;
      last_q <= last_hit_i;
    end
  end

  // scaled offsets
  always_ff @(posedge clk_i) begin
    if (cmd_i.phase == PH_SCALE && cmd_i.step != '0) begin
      raw_q[cmd_i.step[2:0] - 3'd1] <= p_q[32:0];
    end
  end

  // normalizer, one bit position a cycle for all three vectors
  logic [31:0] mmax [3];
  logic [2:0]  vdone, vzero;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      mmax[v]  = (magx_q[v] > magy_q[v]) ? magx_q[v] : magy_q[v];
      vzero[v] = (mmax[v] == '0);
      vdone[v] = vzero[v] || (mmax[v][31:15] == '0 && mmax[v][14]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase == PH_NORM) begin
      for (int v = 0; v < 3; v++) begin
        if (cmd_i.step == '0) begin
          sgx_q[v]  <= raw_q[2*v][32];
          sgy_q[v]  <= raw_q[2*v+1][32];
          magx_q[v] <= raw_q[2*v][32] ? 32'(-raw_q[2*v]) : raw_q[2*v][31:0];
          magy_q[v] <= raw_q[2*v+1][32] ? 32'(-raw_q[2*v+1]) : raw_q[2*v+1][31:0];
        end else if (mmax[v][31:15] != '0) begin
          magx_q[v] <= magx_q[v] >> 1;
          magy_q[v] <= magy_q[v] >> 1;
        end else if (!vdone[v]) begin
          magx_q[v] <= magx_q[v] << 1;
          magy_q[v] <= magy_q[v] << 1;
        end
      end
    end
  end

  // norms, dot product, square root and division
  logic [33:0] s_trial, s_sub;
  logic [32:0] d_trial, d_sub;
  logic [31:0] dmag;

  assign s_trial = {srem_q, rad_q[61:60]};
  assign s_sub   = s_trial - {1'b0, root_q, 2'b01};
  assign d_trial = {drem_q, nbits_q[16]};
  assign d_sub   = d_trial - {2'b0, root_q};
  assign dmag    = dot_q[31] ? 32'(-dot_q) : 32'(dot_q);

  logic signed [16:0] c_new;
  always_comb begin
    if (dot_q[31]) begin
      c_new = (quo_q > 17'd32768) ? -17'sd32768 : -$signed(quo_q);
    end else begin
      c_new = (quo_q > 17'd32767) ? 17'sd32767 : $signed(quo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.phase)
      PH_PROD: begin
        case (cmd_i.step[2:0])
          3'd1: na_q  <= p_q[31:0];
          3'd2: na_q  <= na_q + p_q[31:0];
          3'd3: nb_q  <= p_q[31:0];
          3'd4: nb_q  <= nb_q + p_q[31:0];
          3'd5: dot_q <= p_q[31:0];
          3'd6: dot_q <= dot_q + p_q[31:0];
          3'd7: begin
            rad_q  <= p_q[61:0];
            root_q <= '0;
            srem_q <= '0;
          end
          default: ;
        endcase
      end
      PH_SQRT: begin
        rad_q <= {rad_q[59:0], 2'b00};
        if (!s_sub[33]) begin
          srem_q <= s_sub[31:0];
          root_q <= {root_q[29:0], 1'b1};
        end else begin
          srem_q <= s_trial[31:0];
          root_q <= {root_q[29:0], 1'b0};
        end
      end
      PH_DIV: begin
        if (cmd_i.step == '0) begin
          drem_q  <= {2'b00, dmag[31:2]};
          nbits_q <= {dmag[1:0], 15'b0};
          quo_q   <= '0;
        end else begin
          nbits_q <= {nbits_q[15:0], 1'b0};
          if (!d_sub[32]) begin
            drem_q <= d_sub[31:0];
            quo_q  <= {quo_q[15:0], 1'b1};
          end else begin
            drem_q <= d_trial[31:0];
            quo_q  <= {quo_q[15:0], 1'b0};
          end
        end
      end
      PH_ACC: begin
        if (cmd_i.step == '0) begin
          c_q <= c_new;
        end
      end
      default: ;
    endcase
  end

  // saturating sums
  logic signed [40:0] sum_new;
  logic [48:0]        sq_new;

  always_comb begin
    if (cmd_i.dir) begin
      sum_new = 41'(bsum_q) + 41'(c_q);
      sq_new  = {1'b0, bsq_q} + {18'b0, p_q[30:0]};
    end else begin
      sum_new = 41'(fsum_q) + 41'(c_q);
      sq_new  = {1'b0, fsq_q} + {18'b0, p_q[30:0]};
    end
  end

  logic signed [39:0] sum_sat;
  logic [47:0]        sq_sat;
  assign sum_sat = (sum_new > 41'(CosMax)) ? CosMax :
                   (sum_new < 41'(CosMin)) ? CosMin : sum_new[39:0];
  assign sq_sat  = sq_new[48] ? {48{1'b1}} : sq_new[47:0];

  logic degen_now, keep_now;
  assign degen_now = degen_seen_q || !any_used_q;
  assign keep_now  = !degen_now && (fsum_q > bsum_q) && (fsq_q < bsq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsum_q       <= '0;
      bsum_q       <= '0;
      fsq_q        <= '0;
      bsq_q        <= '0;
      count_q      <= '0;
      any_used_q   <= 1'b0;
      degen_seen_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cmd_i.accept && used_now) begin
        any_used_q <= 1'b1;
        if (count_q != {16{1'b1}}) begin
          count_q <= count_q + 16'd1;
        end
      end
      if (cmd_i.phase == PH_NORM && cmd_i.step != '0 && (&vdone) && (|vzero)) begin
        degen_seen_q <= 1'b1;
      end
      if (cmd_i.phase == PH_ACC && cmd_i.step == ACC_LAST) begin
        if (cmd_i.dir) begin
          bsum_q <= sum_sat;
          bsq_q  <= sq_sat;
        end else begin
          fsum_q <= sum_sat;
          fsq_q  <= sq_sat;
        end
      end
      if (cmd_i.emit) begin
        res_valid_q  <= 1'b1;
        fsum_q       <= '0;
        bsum_q       <= '0;
        fsq_q        <= '0;
        bsq_q        <= '0;
        count_q      <= '0;
        any_used_q   <= 1'b0;
        degen_seen_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      swap_q      <= !keep_now;
      degen_out_q <= degen_now;
      used_q      <= count_q;
    end
  end

  assign status_o.used      = used_now;
  assign status_o.last      = last_q;
  assign status_o.norm_done = &vdone;
  assign status_o.zero_vec  = |vzero;
  assign status_o.out_busy  = res_valid_q && !res_ready_i;

  assign res_valid_o  = res_valid_q;
  assign swap_ends_o  = swap_q;
  assign used_hits_o  = used_q;
  assign degenerate_o = degen_out_q;

endmodule

// ===== sv/cluster_direction_decider_unit.sv =====
// ----------------------------------------------------------------------------
// cluster_direction_decider_unit
// decides whether a cluster's start and end points must be exchanged
// ----------------------------------------------------------------------------
// A hit below the charge cut skips the arithmetic. A used hit goes through
// offset scaling on the shared multiplier and normalization, then per
// direction 8 product steps, 31 steps of the bit-serial square root, 18 steps
// of the bit-serial divider and 3 steps for the sums; a hit on an endpoint or
// a zero axis stops after normalization. The result of the last hit sits in
// an output register, and the next hit is taken while it waits.
module cluster_direction_decider_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cdd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cdd_pkg::DataW-1:0]   cfg_data_i,
  input  logic                        hit_valid_i,
  output logic                        hit_ready_o,
  input  logic [cdd_pkg::DataW-1:0]   hit_w_i,
  input  logic [cdd_pkg::DataW-1:0]   hit_t_i,
  input  logic [cdd_pkg::DataW-1:0]   hit_charge_i,
  input  logic                        last_hit_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic                        swap_ends_o,
  output logic [cdd_pkg::DataW-1:0]   used_hits_o,
  output logic                        degenerate_o
);
  import cdd_pkg::*;

  cmd_t    cmd;
  status_t status;

  cdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_valid_i (hit_valid_i),
    .hit_ready_o (hit_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cdd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .hit_w_i      (hit_w_i),
    .hit_t_i      (hit_t_i),
    .hit_charge_i (hit_charge_i),
    .last_hit_i   (last_hit_i),
    .res_ready_i  (res_ready_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .res_valid_o  (res_valid_o),
    .swap_ends_o  (swap_ends_o),
    .used_hits_o  (used_hits_o),
    .degenerate_o (degenerate_o)
  );

`include "cluster_direction_decider_unit_assert.svh"

  `CDD_ASSERT_NXT(a_emit_shows, cmd.emit, res_valid_o, "emit did not raise result valid")
  `CDD_ASSERT_IMP(a_emit_free, cmd.emit, !res_valid_o || res_ready_i, "result overwritten")
  `CDD_ASSERT_IMP(a_degen_swaps, res_valid_o && degenerate_o, swap_ends_o, "degenerate kept order")

endmodule

// ===== verif/tb_cluster_direction_decider_unit.sv =====
// ----------------------------------------------------------------------------
// tb_cluster_direction_decider_unit
// Drives clusters of hits into the direction decider under several endpoint,
// pitch and charge-cut settings, with random idling on both sides. A built-in
// fixed-point model predicts the swap decision, the used-hit count and the
// degeneracy flag of every cluster, and each result transaction is checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cluster_direction_decider_unit;
  import cdd_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 200;
  localparam longint CosMax = 64'sd549755813887;
  localparam longint CosMin = -64'sd549755813888;
  localparam longint unsigned SqMax = 64'd281474976710655;

  typedef struct {
    logic [DataW-1:0] w;
    logic [DataW-1:0] t;
    logic [DataW-1:0] q;
    logic             last;
  } hit_t;

  typedef struct {
    logic             swap;
    logic [DataW-1:0] used;
    logic             degen;
  } verdict_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;
  logic             hit_valid_i = 1'b0;
  logic             hit_ready_o;
  logic [DataW-1:0] hit_w_i = '0;
  logic [DataW-1:0] hit_t_i = '0;
  logic [DataW-1:0] hit_charge_i = '0;
  logic             last_hit_i = 1'b0;
  logic             res_valid_o;
  logic             res_ready_i = 1'b0;
  logic             swap_ends_o;
  logic [DataW-1:0] used_hits_o;
  logic             degenerate_o;

  cluster_direction_decider_unit dut (.*);

  always #2 clk_i = ~clk_i;

  hit_t     pending_hits[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;
  int       hits_sent = 0;
  int       clusters_checked = 0;
  int       send_idle_pct = 9;
  int       recv_stall_pct = 63;
  bit       hold_request = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_count = 0;
  bit       send_pause = 1'b0;
  bit       hit_taken = 1'b0;
  longint unsigned cycles = 0;

  // register mirror and accumulator state
  logic [DataW-1:0] m_start_w, m_start_t, m_end_w, m_end_t, m_wire_inv, m_time_inv, m_min_q;
  longint          fwd_sum, bwd_sum;
  longint unsigned fwd_sq, bwd_sq;
  logic [DataW-1:0] used_count;
  bit              degen_seen, any_used;

  function automatic longint scaled_offset(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                           logic [DataW-1:0] inv);
    return (longint'({48'd0, a}) - longint'({48'd0, b})) * longint'({48'd0, inv});
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic bit normalize_vec(longint x, longint y, output longint ox, output longint oy);
    longint unsigned mx, my, m;
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    m = mx > my ? mx : my;
    ox = 0;
    oy = 0;
    if (m == 0) return 1'b0;
    while (m >= 32768) begin
      mx >>= 1; my >>= 1; m >>= 1;
    end
    while (m < 16384) begin
      mx <<= 1; my <<= 1; m <<= 1;
    end
    ox = x < 0 ? -longint'(mx) : longint'(mx);
    oy = y < 0 ? -longint'(my) : longint'(my);
    return 1'b1;
  endfunction

  function automatic longint axis_cosine(longint ax, longint ay, longint bx, longint by);
    longint dot;
    longint unsigned na, nb, den, mag, quo;
    dot = ax * bx + ay * by;
    na = ax * ax + ay * ay;
    nb = bx * bx + by * by;
    den = floor_sqrt(na * nb);
    if (den == 0) return 0;
    mag = dot < 0 ? -dot : dot;
    quo = (mag << 15) / den;
    if (dot < 0) return quo > 32768 ? -32768 : -longint'(quo);
    return quo > 32767 ? 32767 : longint'(quo);
  endfunction

  function automatic void accumulate_cos(ref longint s, ref longint unsigned sq, input longint c);
    longint ns;
    longint unsigned nq;
    ns = s + c;
    nq = sq + longint'(c * c);
    s = ns > CosMax ? CosMax : (ns < CosMin ? CosMin : ns);
    sq = nq > SqMax ? SqMax : nq;
  endfunction

  function automatic void clear_cluster();
    fwd_sum = 0; bwd_sum = 0; fwd_sq = 0; bwd_sq = 0;
    used_count = 0; degen_seen = 0; any_used = 0;
  endfunction

  function automatic void predict_hit(hit_t h);
    longint ax, ay, fx, fy, bx, by;
    bit oka, okf, okb, dg;
    verdict_t v;
    if (h.q >= m_min_q) begin
      oka = normalize_vec(scaled_offset(m_end_w, m_start_w, m_wire_inv),
                          scaled_offset(m_end_t, m_start_t, m_time_inv), ax, ay);
      okf = normalize_vec(scaled_offset(h.w, m_start_w, m_wire_inv),
                          scaled_offset(h.t, m_start_t, m_time_inv), fx, fy);
      okb = normalize_vec(scaled_offset(h.w, m_end_w, m_wire_inv),
                          scaled_offset(h.t, m_end_t, m_time_inv), bx, by);
      any_used = 1;
      if (used_count != 16'hFFFF) used_count++;
      if (oka && okf && okb) begin
        accumulate_cos(fwd_sum, fwd_sq, axis_cosine(ax, ay, fx, fy));
        accumulate_cos(bwd_sum, bwd_sq, axis_cosine(ax, ay, bx, by));
      end else begin
        degen_seen = 1;
      end
    end
    if (h.last) begin
      dg = degen_seen || !any_used;
      v.swap = !(!dg && fwd_sum > bwd_sum && fwd_sq < bwd_sq);
      v.used = used_count;
      v.degen = dg;
      expected_verdicts = {expected_verdicts, v};
      clear_cluster();
    end
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // hit driver
  always @(posedge clk_i) hit_taken <= hit_valid_i && hit_ready_o;

  always @(negedge clk_i) begin
    if (rst_ni && (!hit_valid_i || hit_taken)) begin
      if (pending_hits.size() > 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        hit_t h;
        h = pending_hits.pop_front();
        hit_w_i <= h.w;
        hit_t_i <= h.t;
        hit_charge_i <= h.q;
        last_hit_i <= h.last;
        hit_valid_i <= 1'b1;
      end else begin
        hit_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with one long hold-off
  always @(negedge clk_i) begin
    if (hold_request && !hold_done && hold_count == 0) begin
      hold_count <= 2000;
      hold_done <= 1'b1;
      res_ready_i <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      res_ready_i <= 1'b0;
    end else begin
      res_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted hits, check accepted results
  always @(posedge clk_i) begin
    if (hit_valid_i && hit_ready_o) begin
      hit_t h;
      h.w = hit_w_i; h.t = hit_t_i; h.q = hit_charge_i; h.last = last_hit_i;
      hits_sent++;
      predict_hit(h);
    end
    if (res_valid_o && res_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected transaction swap=%0b used=%0d degen=%0b",
                 $time, swap_ends_o, used_hits_o, degenerate_o);
        errors++;
      end else begin
        verdict_t v;
        v = expected_verdicts.pop_front();
        clusters_checked++;
        if (swap_ends_o !== v.swap) begin
          $display("%0t: swap_ends expected %0b actual %0b", $time, v.swap, swap_ends_o);
          errors++;
        end
        if (used_hits_o !== v.used) begin
          $display("%0t: used_hits expected %0d actual %0d", $time, v.used, used_hits_o);
          errors++;
        end
        if (degenerate_o !== v.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, v.degen, degenerate_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_START_W:    m_start_w = val;
      REG_START_T:    m_start_t = val;
      REG_END_W:      m_end_w = val;
      REG_END_T:      m_end_t = val;
      REG_WIRE_INV:   m_wire_inv = val;
      REG_TIME_INV:   m_time_inv = val;
      REG_MIN_CHARGE: m_min_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(logic [DataW-1:0] sw, logic [DataW-1:0] st, logic [DataW-1:0] ew,
                              logic [DataW-1:0] et, logic [DataW-1:0] wi, logic [DataW-1:0] ti,
                              logic [DataW-1:0] mq);
    write_reg(REG_START_W, sw);
    write_reg(REG_START_T, st);
    write_reg(REG_END_W, ew);
    write_reg(REG_END_T, et);
    write_reg(REG_WIRE_INV, wi);
    write_reg(REG_TIME_INV, ti);
    write_reg(REG_MIN_CHARGE, mq);
  endtask

  task automatic add_hit(logic [DataW-1:0] w, logic [DataW-1:0] t, logic [DataW-1:0] q, logic l);
    hit_t h;
    h.w = w; h.t = t; h.q = q; h.last = l;
    pending_hits = {pending_hits, h};
  endtask

  task automatic wait_quiet();
    while (pending_hits.size() > 0 || hit_valid_i || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random cluster along the configured axis, with some noise hits
  task automatic add_cluster();
    int n, f, dw, dt;
    logic [DataW-1:0] w, t, q;
    n = $urandom_range(8, 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        w = 16'($urandom); t = 16'($urandom);
      end else begin
        f = int'($urandom_range(120)) - 10;
        dw = int'($urandom_range(64)) - 32;
        dt = int'($urandom_range(64)) - 32;
        w = 16'(int'(m_start_w) + (int'(m_end_w) - int'(m_start_w)) * f / 100 + dw);
        t = 16'(int'(m_start_t) + (int'(m_end_t) - int'(m_start_t)) * f / 100 + dt);
      end
      q = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(int'(m_min_q) + 60));
      add_hit(w, t, q, k == n - 1);
    end
  endtask

  initial begin
    m_start_w = 0; m_start_t = 0; m_end_w = 0; m_end_t = 0;
    m_wire_inv = INV_PITCH_RST; m_time_inv = INV_PITCH_RST; m_min_q = MIN_CHARGE_RST;
    clear_cluster();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset settings: zero-length axis, and a cluster with no used hit
    add_hit(16'd100, 16'd200, 16'd100, 1'b0);
    add_hit(16'd300, 16'd50, 16'd30, 1'b1);
    add_hit(16'd5, 16'd5, 16'd24, 1'b1);
    wait_quiet();

    set_geometry(16'd1600, 16'd3200, 16'd14400, 16'd11200, 16'd4096, 16'd4096, 16'd25);
    add_hit(16'd1600, 16'd3200, 16'd25, 1'b1);          // on start point
    add_hit(16'd14400, 16'd11200, 16'hFFFF, 1'b1);      // on end point
    add_hit(16'd0, 16'd0, 16'd24, 1'b0);                // below cut
    add_hit(16'd4000, 16'd5000, 16'd25, 1'b0);
    add_hit(16'd8000, 16'd7000, 16'd500, 1'b1);
    add_hit(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_hit(16'd0, 16'd0, 16'd1000, 1'b1);
    add_hit(16'd2000, 16'd3500, 16'd40, 1'b0);
    add_hit(16'd3000, 16'd4200, 16'd40, 1'b0);
    add_hit(16'd13000, 16'd10500, 16'd40, 1'b1);
    wait_quiet();

    // extreme endpoints and pitches, zero pitch collapses one axis
    set_geometry(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    add_hit(16'd100, 16'd9, 16'd0, 1'b0);
    add_hit(16'h8000, 16'h8000, 16'd7, 1'b1);
    add_hit(16'd0, 16'd7, 16'd0, 1'b1);
    wait_quiet();
    set_geometry(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    add_hit(16'h1234, 16'hABCD, 16'hFFFF, 1'b0);
    add_hit(16'hFFFF, 16'h0, 16'hFFFE, 1'b1);
    add_hit(16'h7000, 16'h9000, 16'hFFFF, 1'b1);
    wait_quiet();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 63; recv_stall_pct = 9;
      end else if (ph == 8) begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      set_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(1) ? $urandom_range(8192, 512) : $urandom),
                   16'($urandom_range(1) ? $urandom_range(8192, 512) : $urandom),
                   16'($urandom_range(3) == 0 ? $urandom : $urandom_range(200)));
      while (pending_hits.size() < 100) add_cluster();
      if (ph == 9) begin
        hold_request = 1'b1;
        // sender pauses until every cluster so far has been decided
        while (pending_hits.size() > 50) @(posedge clk_i);
        send_pause = 1'b1;
        while (hit_valid_i || expected_verdicts.size() > 0) @(posedge clk_i);
        send_pause = 1'b0;
      end
      wait_quiet();
    end

    $display("run covered %0d hits and %0d cluster decisions over 16 register settings",
             hits_sent, clusters_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
